FILE: design/sitda_pkg.sv
package sitda_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam int         RADIX      = 10;
    localparam int         MAX_DIGITS = 20;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic emit;
        logic pos_zero;
    } t_status;

    // Decimal digit count of 2^(w-1), the largest magnitude at width w.
    function automatic int digits_of_width(input int w);
        logic [63:0] v;
        int          n;
        v = 64'd1 << (w - 1);
        n = 0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (v != 64'd0) begin
                v = v / RADIX;
                n = n + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] pow10(input logic [4:0] k);
        logic [63:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            5'd19:   p = 64'd10000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: design/sitda_ctrl.sv
module sitda_ctrl
    import sitda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SIGN  = 2'd1;
    localparam logic [1:0] S_DIGIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    // The output register can take a character when it is empty or being drained.
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SIGN;
                end
            end
            S_SIGN: begin
                if (!i_st.negative) begin
                    n_state = S_DIGIT;
                end else if (out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                // Leading zero positions are skipped without waiting on the output.
                if (!i_st.emit || out_free) begin
                    o_cmd.step       = 1'b1;
                    o_cmd.emit_digit = i_st.emit;
                    if (i_st.pos_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit_sign || o_cmd.emit_digit) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load issued outside idle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_sign || o_cmd.emit_digit) |-> out_free)
        else $error("character written over a pending transfer");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_st.pos_zero) |=> r_state == S_IDLE)
        else $error("no return to idle after the units digit");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_sign && o_cmd.emit_digit))
        else $error("sign and digit emitted together");

endmodule

FILE: design/sitda_dp.sv
module sitda_dp
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  t_cmd                          i_cmd,
    output t_status                       o_st,
    output logic [7:0]                    o_char_code,
    output logic                          o_last
);

    localparam int NDIG = digits_of_width(VALUE_WIDTH);
    localparam int PW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int XW   = VALUE_WIDTH + 4;

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [PW-1:0]          r_pos;
    logic                   r_neg;
    logic                   r_started;
    logic [7:0]             r_char;
    logic                   r_last;

    logic [XW-1:0] pw;
    logic [XW-1:0] mult [0:9];
    logic [XW-1:0] mag_x;
    logic [3:0]    digit;
    logic [XW-1:0] rest;

    assign pw    = XW'(pow10(5'(r_pos)));
    assign mag_x = XW'(r_mag);

    // The digit at this position is the largest multiple of its power of ten
    // that still fits in the remaining magnitude.
    always_comb begin
        digit = 4'd0;
        for (int j = 0; j < 10; j++) begin
            mult[j] = pw * XW'(j);
        end
        for (int j = 1; j < 10; j++) begin
            if (mag_x >= mult[j]) begin
                digit = 4'(j);
            end
        end
    end

    assign rest = mag_x - mult[digit];

    assign o_st.negative = r_neg;
    assign o_st.pos_zero = (r_pos == '0);
    assign o_st.emit     = (digit != 4'd0) || r_started || (r_pos == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg     <= i_value[VALUE_WIDTH-1];
            r_mag     <= i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            r_pos     <= PW'(NDIG - 1);
            r_started <= 1'b0;
        end else if (i_cmd.step) begin
            r_mag     <= rest[VALUE_WIDTH-1:0];
            r_pos     <= r_pos - 1'b1;
            r_started <= r_started || o_st.emit;
        end
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= CHAR_ZERO + {4'd0, digit};
            r_last <= (r_pos == '0);
        end
    end

    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

FILE: design/signed_int_to_decimal_ascii.sv
// Converts one signed integer to its decimal ASCII text, most significant first.
// An item passes through a load step, a sign step and one step per decimal position
// (10 at 32 bits); the extractor handles one position per cycle unless the output stalls.
// A new value is not taken until the units position is done. The first character is
// the minus sign for a negative value, else the first nonzero digit (units for zero).
// Synchronous active-low reset clears the state machine and output valid.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_char_code,
    output logic                          o_last
);

    t_cmd    cmd;
    t_status st;

    sitda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    sitda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule
